>>> design/msce_pkg.sv
// Shared types, constants and the cell segment table of the marching squares edge block.
// Used by msce_scan, msce_emit and marching_squares_contour_edges.
package msce_pkg;

    // Largest image the line store and counters are built for
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

    // Field widths fixed by the interface
    localparam int DIM_W      = 11;
    localparam int COORD_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    // Counter and line store address widths
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = $clog2(MAX_WIDTH);

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

    // Cell edge midpoints
    localparam logic [1:0] VTX_A = 2'd0; // bottom
    localparam logic [1:0] VTX_B = 2'd1; // right
    localparam logic [1:0] VTX_C = 2'd2; // top
    localparam logic [1:0] VTX_D = 2'd3; // left

    typedef struct packed {
        logic [1:0] from_v;
        logic [1:0] to_v;
    } seg_t;

    typedef struct packed {
        logic [1:0] count;
        seg_t       first;
        seg_t       second;
    } cell_segs_t;

    // One scanned position handed from the scan stage to the emit stage
    typedef struct packed {
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic             here;      // top-right corner, padding already masked
        logic             left;      // top-left corner, masked in column 0
        logic             above_ok;  // bottom-right corner may be read from line store
        logic             corner_ok; // bottom-left corner may be used
    } scan_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_x;
    } seg_coord_t;

    // Corner code to directed segments, filled side on the left
    function automatic cell_segs_t cell_lookup(input logic [3:0] code);
        cell_segs_t s;
        s = '0;
        case (code)
            4'd1:  s = '{2'd1, '{VTX_A, VTX_D}, '{VTX_A, VTX_A}};
            4'd2:  s = '{2'd1, '{VTX_B, VTX_A}, '{VTX_A, VTX_A}};
            4'd3:  s = '{2'd1, '{VTX_B, VTX_D}, '{VTX_A, VTX_A}};
            4'd4:  s = '{2'd1, '{VTX_C, VTX_B}, '{VTX_A, VTX_A}};
            4'd5:  s = '{2'd2, '{VTX_A, VTX_B}, '{VTX_C, VTX_D}};
            4'd6:  s = '{2'd1, '{VTX_C, VTX_A}, '{VTX_A, VTX_A}};
            4'd7:  s = '{2'd1, '{VTX_C, VTX_D}, '{VTX_A, VTX_A}};
            4'd8:  s = '{2'd1, '{VTX_D, VTX_C}, '{VTX_A, VTX_A}};
            4'd9:  s = '{2'd1, '{VTX_A, VTX_C}, '{VTX_A, VTX_A}};
            4'd10: s = '{2'd2, '{VTX_D, VTX_A}, '{VTX_B, VTX_C}};
            4'd11: s = '{2'd1, '{VTX_B, VTX_C}, '{VTX_A, VTX_A}};
            4'd12: s = '{2'd1, '{VTX_D, VTX_B}, '{VTX_A, VTX_A}};
            4'd13: s = '{2'd1, '{VTX_A, VTX_B}, '{VTX_A, VTX_A}};
            4'd14: s = '{2'd1, '{VTX_D, VTX_A}, '{VTX_A, VTX_A}};
            default: s = '0; // empty or full cell
        endcase
        return s;
    endfunction

endpackage

>>> design/msce_scan.sv
// Scan stage: config registers, raster counters, line store of the previous row.
// Depends on msce_pkg.
module msce_scan (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [msce_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [msce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [msce_pkg::DIM_W-1:0]         cfg_data,
    output msce_pkg::scan_item_t               item,
    output logic                               item_valid,
    output logic                               above_bit,
    input  logic                               retire
);
    import msce_pkg::*;

    logic [DIM_W-1:0]  grid_width_reg;
    logic [DIM_W-1:0]  grid_height_reg;
    logic [CNT_W-1:0]  w_eff;
    logic [CNT_W-1:0]  h_eff;
    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  col_next;
    logic [CNT_W-1:0]  row_next;
    logic [CNT_W-1:0]  fill_reg;   // entries [0, fill) written since reset
    logic              left_bit_reg;
    logic              in_col;
    logic              in_row;
    logic              accept;
    logic              here;
    scan_item_t        item_reg;
    scan_item_t        item_next;
    logic              item_valid_reg;
    logic              line_mem [MAX_WIDTH];
    logic              rd_reg;
    logic [ADDR_W-1:0] addr;

    // Config writes land at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_W'(1024);
            grid_height_reg <= DIM_W'(1024);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_GRID_WIDTH)
                grid_width_reg <= cfg_data;
            else if (cfg_index == REG_GRID_HEIGHT)
                grid_height_reg <= cfg_data;
        end
    end

    // Clamp dimensions: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = CNT_W'(1);
        else if (int'(grid_width_reg) > MAX_WIDTH)
            w_eff = CNT_W'(MAX_WIDTH);
        else
            w_eff = CNT_W'(grid_width_reg);

        if (grid_height_reg == '0)
            h_eff = CNT_W'(1);
        else if (int'(grid_height_reg) > MAX_HEIGHT)
            h_eff = CNT_W'(MAX_HEIGHT);
        else
            h_eff = CNT_W'(grid_height_reg);
    end

    // Handshake: the stage register frees when the emit side retires it
    assign s_tready = !item_valid_reg || retire;
    assign accept   = s_tvalid && s_tready;

    assign in_col = col_reg < w_eff;
    assign in_row = row_reg < h_eff;
    assign here   = in_col && in_row && s_tdata[0];
    assign addr   = col_reg[ADDR_W-1:0];

    // Raster position advance
    always_comb
    begin
        if (!in_col)
        begin
            col_next = '0;
            row_next = in_row ? row_reg + CNT_W'(1) : '0;
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
            row_next = row_reg;
        end
    end

    always_comb
    begin
        item_next.col       = col_reg;
        item_next.row       = row_reg;
        item_next.here      = here;
        item_next.left      = (col_reg != '0) && left_bit_reg;
        item_next.above_ok  = in_col && (row_reg != '0) && (col_reg < fill_reg);
        item_next.corner_ok = (col_reg != '0) && (row_reg != '0);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            fill_reg       <= '0;
            left_bit_reg   <= 1'b0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                left_bit_reg <= here;
                if (in_col && (col_reg >= fill_reg))
                    fill_reg <= col_reg + CNT_W'(1);
            end
            if (accept)
                item_valid_reg <= 1'b1;
            else if (retire)
                item_valid_reg <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    // Line store: read-first, so the read sees the row above
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= line_mem[addr];
            if (in_col)
                line_mem[addr] <= here;
        end
    end

    assign item       = item_reg;
    assign item_valid = item_valid_reg;
    assign above_bit  = rd_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= MAX_WIDTH)
        else $error("line store fill count beyond depth");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(col_reg) <= MAX_WIDTH)
        else $error("column counter beyond padded width");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !retire |=> item_valid_reg && $stable(item_reg) && $stable(rd_reg))
        else $error("stage word changed while stalled");

endmodule

>>> design/msce_emit.sv
// Emit stage: corner code, segment table lookup, one word per cycle to a free output register.
// Depends on msce_pkg.
module msce_emit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  msce_pkg::scan_item_t                item,
    input  logic                                item_valid,
    input  logic                                above_bit,
    output logic                                retire,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [msce_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);
    import msce_pkg::*;

    logic                      left_above_reg;
    logic                      seg_idx_reg;
    logic                      out_valid_reg;
    logic                      out_last_reg;
    seg_coord_t                out_seg_reg;
    seg_coord_t                seg_next;
    logic                      p1;
    logic                      p2;
    logic [3:0]                code;
    cell_segs_t                segs;
    seg_t                      cur;
    logic                      is_last;
    logic                      out_free;
    logic                      emit_fire;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] ry;

    function automatic logic signed [COORD_W-1:0] vtx_x(input logic [1:0] v,
                                                        input logic signed [COORD_W-1:0] x);
        logic signed [COORD_W-1:0] r;
        r = x;
        case (v)
            VTX_A:   r = x - COORD_W'(1);
            VTX_B:   r = x;
            VTX_C:   r = x - COORD_W'(1);
            default: r = x - COORD_W'(2);
        endcase
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] vtx_y(input logic [1:0] v,
                                                        input logic signed [COORD_W-1:0] y);
        logic signed [COORD_W-1:0] r;
        r = y;
        case (v)
            VTX_A:   r = y - COORD_W'(2);
            VTX_B:   r = y - COORD_W'(1);
            VTX_C:   r = y;
            default: r = y - COORD_W'(1);
        endcase
        return r;
    endfunction

    // Corner code: bit0 bottom-left, bit1 bottom-right, bit2 top-right, bit3 top-left
    assign p2   = item.above_ok && above_bit;
    assign p1   = item.corner_ok && left_above_reg;
    assign code = {item.left, item.here, p2, p1};
    assign segs = cell_lookup(code);
    assign cur  = seg_idx_reg ? segs.second : segs.first;

    assign is_last   = (segs.count == 2'd1) || seg_idx_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign emit_fire = item_valid && (segs.count != 2'd0) && out_free;
    assign retire    = item_valid && ((segs.count == 2'd0) || (out_free && is_last));

    // Half-pixel coordinates, wrapped to the field width
    assign cx = COORD_W'({item.col, 1'b0});
    assign ry = COORD_W'({item.row, 1'b0});

    always_comb
    begin
        seg_next.start_x = vtx_x(cur.from_v, cx);
        seg_next.start_y = vtx_y(cur.from_v, ry);
        seg_next.end_x   = vtx_x(cur.to_v, cx);
        seg_next.end_y   = vtx_y(cur.to_v, ry);
    end

    // Segment sequencing and output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_above_reg <= 1'b0;
            seg_idx_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (retire)
                left_above_reg <= p2;
            if (emit_fire)
                seg_idx_reg <= !is_last;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_seg_reg  <= seg_next;
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_seg_reg);
    assign m_tlast  = out_last_reg;

    a_idx_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        seg_idx_reg |-> item_valid)
        else $error("second segment pending without a stage word");

    a_idx_saddle: assert property (@(posedge clk) disable iff (!rst_n)
        seg_idx_reg |-> segs.count == 2'd2)
        else $error("second segment pending on a non-saddle cell");

    a_retire_sends: assert property (@(posedge clk) disable iff (!rst_n)
        retire && (segs.count != 2'd0) |-> emit_fire && is_last)
        else $error("cell retired before its last segment went out");

    a_nonzero_seg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_seg_reg.start_x != out_seg_reg.end_x)
                          || (out_seg_reg.start_y != out_seg_reg.end_y))
        else $error("degenerate segment in output word");

endmodule

>>> design/marching_squares_contour_edges.sv
// A mask word is registered in the scan stage, its segment words in the output register.
// Throughput: one mask word per cycle unless the output stalls; a saddle cell holds the
// input for its second segment word, as the single output register takes one per cycle.
// Reset: rst_n clears counters, fill count of the line store and grid size (1024 x 1024);
// the line store is not swept, entries past the fill count read as empty. Top level.
module marching_squares_contour_edges (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [msce_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] filled, [7:1] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [msce_pkg::OUT_TDATA_W-1:0]   m_tdata,   // start_x, start_y, end_x, end_y
    output logic                               m_tlast,   // last_of_run
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [msce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [msce_pkg::DIM_W-1:0]         cfg_data
);
    import msce_pkg::*;

    scan_item_t item;
    logic       item_valid;
    logic       above_bit;
    logic       retire;

    // Raster scan and line store
    msce_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (item),
        .item_valid (item_valid),
        .above_bit  (above_bit),
        .retire     (retire)
    );

    // Cell code and segment output
    msce_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .above_bit  (above_bit),
        .retire     (retire),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> tb/marching_squares_contour_edges_tb.sv
// Self-checking bench for marching_squares_contour_edges: streams padded mask frames,
// predicts the directed boundary segments of each cell and checks every output word.
// Depends on msce_pkg and the marching_squares_contour_edges RTL.
module marching_squares_contour_edges_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msce_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 6;

    // Corner codes with special handling
    localparam logic [3:0] CELL_EMPTY  = 4'd0;
    localparam logic [3:0] CELL_FULL   = 4'd15;
    localparam logic [3:0] SADDLE_LOW  = 4'd5;  // bottom-left and top-right filled
    localparam logic [3:0] SADDLE_HIGH = 4'd10; // bottom-right and top-left filled

    // {start vertex, end vertex} of the first segment per corner code
    localparam logic [3:0] FIRST_SEG [16] = '{
        4'h0,           {VTX_A, VTX_D}, {VTX_B, VTX_A}, {VTX_B, VTX_D},
        {VTX_C, VTX_B}, {VTX_A, VTX_B}, {VTX_C, VTX_A}, {VTX_C, VTX_D},
        {VTX_D, VTX_C}, {VTX_A, VTX_C}, {VTX_D, VTX_A}, {VTX_B, VTX_C},
        {VTX_D, VTX_B}, {VTX_A, VTX_B}, {VTX_D, VTX_A}, 4'h0
    };
    // Second segment of the saddles
    localparam logic [3:0] SADDLE_LOW_SEG  = {VTX_C, VTX_D};
    localparam logic [3:0] SADDLE_HIGH_SEG = {VTX_B, VTX_C};

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic                      last;
    } contour_seg_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]       cfg_data;

    // Predictor state
    logic         line_bits [MAX_WIDTH];
    logic         prev_here;
    logic         prev_above;
    int unsigned  cur_col;
    int unsigned  cur_row;
    logic [DIM_W-1:0] mask_cols;
    logic [DIM_W-1:0] mask_rows;

    contour_seg_t pending_segs [$];
    int           err_count;
    int           cycle_count;
    int           masks_sent;
    int           send_gap_pct;
    int           take_stall_pct;

    marching_squares_contour_edges dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Zero acts as 1, anything above the build limit acts as the limit
    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] raw, input int unsigned lim);
        if (raw == '0)
            return 1;
        if (raw > lim)
            return lim;
        return raw;
    endfunction

    function automatic contour_seg_t make_seg(input logic [3:0] pair, input int vx [4],
                                              input int vy [4], input logic last);
        contour_seg_t seg;
        seg.sx   = COORD_W'(vx[pair[3:2]]);
        seg.sy   = COORD_W'(vy[pair[3:2]]);
        seg.ex   = COORD_W'(vx[pair[1:0]]);
        seg.ey   = COORD_W'(vy[pair[1:0]]);
        seg.last = last;
        return seg;
    endfunction

    // Advance the scan position by one mask word and queue the segments of the finished cell
    function automatic void predict_cell(input logic filled);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic        bl;
        logic        br;
        logic        tr;
        logic        tl;
        logic [3:0]  code;
        int          vx [4];
        int          vy [4];
        w  = eff_dim(mask_cols, MAX_WIDTH);
        h  = eff_dim(mask_rows, MAX_HEIGHT);
        c  = cur_col;
        r  = cur_row;
        tr = (c < w && r < h) ? filled : 1'b0;
        br = (c < w && r > 0) ? line_bits[c] : 1'b0;
        bl = (c > 0 && r > 0) ? prev_above : 1'b0;
        tl = (c > 0) ? prev_here : 1'b0;
        if (c < w)
            line_bits[c] = tr;
        prev_here  = tr;
        prev_above = br;
        code = {tl, tr, br, bl};

        // edge midpoints in half-pixel units
        vx[VTX_A] = 2 * int'(c) - 1; vy[VTX_A] = 2 * int'(r) - 2;
        vx[VTX_B] = 2 * int'(c);     vy[VTX_B] = 2 * int'(r) - 1;
        vx[VTX_C] = 2 * int'(c) - 1; vy[VTX_C] = 2 * int'(r);
        vx[VTX_D] = 2 * int'(c) - 2; vy[VTX_D] = 2 * int'(r) - 1;

        if (code == SADDLE_LOW)
        begin
            pending_segs.insert(pending_segs.size(), make_seg(FIRST_SEG[code], vx, vy, 1'b0));
            pending_segs.insert(pending_segs.size(), make_seg(SADDLE_LOW_SEG, vx, vy, 1'b1));
        end
        else if (code == SADDLE_HIGH)
        begin
            pending_segs.insert(pending_segs.size(), make_seg(FIRST_SEG[code], vx, vy, 1'b0));
            pending_segs.insert(pending_segs.size(), make_seg(SADDLE_HIGH_SEG, vx, vy, 1'b1));
        end
        else if (code != CELL_EMPTY && code != CELL_FULL)
            pending_segs.insert(pending_segs.size(), make_seg(FIRST_SEG[code], vx, vy, 1'b1));

        if (c >= w)
        begin
            cur_col = 0;
            cur_row = (r >= h) ? 0 : r + 1;
        end
        else
            cur_col = c + 1;
    endfunction

    // Send one mask word, idling at random first
    task automatic send_mask(input logic filled);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = IN_TDATA_W'(filled);
        do
            @(posedge clk);
        while (!s_tready);
        predict_cell(filled);
        masks_sent++;
    endtask

    // Stop the stream and let every queued segment come out
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_segs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_GRID_WIDTH)
            mask_cols = value;
        else if (idx == REG_GRID_HEIGHT)
            mask_rows = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random words until the scan position is back at the frame origin
    task automatic finish_frame();
        while (cur_col != 0 || cur_row != 0)
            send_mask(1'($urandom_range(0, 1)));
    endtask

    task automatic set_idling(input int send_pct, input int take_pct);
        send_gap_pct   = send_pct;
        take_stall_pct = take_pct;
    endtask

    // A few words at the reset size of 1024 x 1024
    task automatic test_reset_size();
        repeat (12) send_mask(1'($urandom_range(0, 1)));
    endtask

    // Checkerboards on a 2 x 2 image give both saddles; padding words are sent as filled
    task automatic test_saddles();
        logic [8:0] diag_up;
        logic [8:0] diag_down;
        diag_up   = 9'b1_1111_0101;
        diag_down = 9'b1_1110_1110;
        write_reg(REG_GRID_WIDTH, DIM_W'(2));
        write_reg(REG_GRID_HEIGHT, DIM_W'(2));
        finish_frame();
        for (int i = 0; i < 9; i++)
            send_mask(diag_up[i]);
        for (int i = 0; i < 9; i++)
            send_mask(diag_down[i]);
    endtask

    // Zero and oversized register values, tallest image, resize mid-frame
    task automatic test_grid_limits();
        write_reg(REG_GRID_WIDTH, '0);
        write_reg(REG_GRID_HEIGHT, '0);
        repeat (8) send_mask(1'b1);
        write_reg(REG_GRID_WIDTH, '1);
        repeat (40) send_mask(1'($urandom_range(0, 1)));
        write_reg(REG_GRID_WIDTH, DIM_W'(1));
        write_reg(REG_GRID_HEIGHT, DIM_W'(MAX_HEIGHT));
        repeat (30) send_mask(1'($urandom_range(0, 1)));
        write_reg(REG_GRID_HEIGHT, '1);
        repeat (10) send_mask(1'($urandom_range(0, 1)));
        write_reg(REG_GRID_HEIGHT, DIM_W'(3));
        finish_frame();
    endtask

    // Random frames of random size and density; some are cut short and resized mid-frame
    task automatic test_random_frames(input int n_words);
        int stop_at;
        int w;
        int h;
        int density;
        int frame_len;
        stop_at = masks_sent + n_words;
        while (masks_sent < stop_at)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            case ($urandom_range(0, 2))
                0: density = 10;
                1: density = 50;
                default: density = 90;
            endcase
            write_reg(REG_GRID_WIDTH, DIM_W'(w));
            write_reg(REG_GRID_HEIGHT, DIM_W'(h));
            finish_frame();
            frame_len = (w + 1) * (h + 1);
            if ($urandom_range(0, 7) == 0)
                frame_len = $urandom_range(1, frame_len - 1);
            repeat (frame_len) send_mask($urandom_range(0, 99) < density);
        end
        finish_frame();
    endtask

    // Receiver stalls
    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= take_stall_pct);

    task automatic check_field(input string name, input logic signed [COORD_W-1:0] want,
                               input logic signed [COORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Compare each segment word with the oldest expectation
    always @(posedge clk)
    begin : seg_check
        contour_seg_t got;
        contour_seg_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.sx   = m_tdata[COORD_W-1:0];
            got.sy   = m_tdata[2*COORD_W-1:COORD_W];
            got.ex   = m_tdata[3*COORD_W-1:2*COORD_W];
            got.ey   = m_tdata[4*COORD_W-1:3*COORD_W];
            got.last = m_tlast;
            if (pending_segs.size() == 0)
            begin
                $display("%0t: unexpected segment word, expected none got (%0d,%0d)>(%0d,%0d) last %0b",
                         $time, got.sx, got.sy, got.ex, got.ey, got.last);
                err_count++;
            end
            else
            begin
                want = pending_segs.pop_front();
                check_field("start_x", want.sx, got.sx);
                check_field("start_y", want.sy, got.sy);
                check_field("end_x", want.ex, got.ex);
                check_field("end_y", want.ey, got.ey);
                check_field("last_of_run", COORD_W'(want.last), COORD_W'(got.last));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("marching_squares_contour_edges_tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_GRID_WIDTH;
        cfg_data       = '0;
        err_count      = 0;
        cycle_count    = 0;
        masks_sent     = 0;
        prev_here      = 1'b0;
        prev_above     = 1'b0;
        cur_col        = 0;
        cur_row        = 0;
        mask_cols      = DIM_W'(MAX_WIDTH);
        mask_rows      = DIM_W'(MAX_HEIGHT);
        foreach (line_bits[i])
            line_bits[i] = 1'b0;
        set_idling(34, 51);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_size();
        test_saddles();
        test_grid_limits();
        test_random_frames(140);
        set_idling(51, 34);
        test_random_frames(140);
        set_idling(0, 0);
        test_random_frames(140);
        drain();

        if (err_count == 0)
            $display("marching_squares_contour_edges_tb: clean");
        else
            $display("marching_squares_contour_edges_tb: errors");
        $finish;
    end

endmodule
